/* hdl/shbi_pkg.sv */
// Shared types, constants and hash functions for the string hash bucket index block.
// No dependencies; used by every other file in the block.
`timescale 1ns / 1ps

package shbi_pkg;

    localparam int HASH_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int DIV_STEPS = HASH_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int OUT_W     = 2 * HASH_W;

    // Bucket count after reset
    localparam logic [HASH_W-1:0] BUCKET_RESET = 32'd256;

    // Clock edges from the last beat of a key to the first edge that can take its result
    localparam int RESULT_LATENCY = DIV_STEPS + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINAL,
        ST_DIV,
        ST_DONE
    } shbi_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic mix_en;
        logic final_en;
        logic div_step;
        logic load_out;
    } shbi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } shbi_status_t;

    // One byte step of the one-at-a-time hash
    function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    // Final avalanche
    function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

/* hdl/string_hash_bucket_index.sv */
// Top level of the string hash bucket index block.
// Depends on shbi_pkg, shbi_ctrl and shbi_dp.
`timescale 1ns / 1ps

// Streams key bytes, one beat per byte, into a 32-bit one-at-a-time hash.
// A beat that is not the last of a key leaves the block ready again in the
// next cycle. The beat with tlast starts the final mix, then a bit-serial
// remainder unit for hash modulo num_buckets, then the load of the output
// register; the input is not ready from the last beat until the result has
// gone into the output register. A result waiting on the output does not
// stall non-last bytes of the next key. tuser high marks a byte that belongs
// to the key; a tlast beat with tuser low ends the key without a byte (an
// empty key hashes to 0). A bucket count of 0 acts as 2^32.
// Write num_buckets only while no key is in flight.

module string_hash_bucket_index
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [shbi_pkg::HASH_W-1:0]         cfg_wr_data,   // num_buckets
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [shbi_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] key_byte
    input  logic                                s_axis_tuser,  // [0] byte_present
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [shbi_pkg::OUT_W-1:0]          m_axis_tdata   // [31:0] full_hash,
                                                               // [63:32] bucket_sel
);

    shbi_pkg::shbi_cmd_t    cmd;
    shbi_pkg::shbi_status_t status;

    shbi_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    shbi_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_byte    (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_axis_tdata)
    );

endmodule

/* hdl/shbi_ctrl.sv */
// Controller FSM for the string hash bucket index block.
// Depends on shbi_pkg; drives the datapath through shbi_cmd_t.
`timescale 1ns / 1ps

module shbi_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  shbi_pkg::shbi_status_t status,
    output shbi_pkg::shbi_cmd_t    cmd
);

    shbi_pkg::shbi_state_t state_reg;
    shbi_pkg::shbi_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_beat;
    logic                  out_free;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shbi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            shbi_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.mix_en    = in_beat && s_axis_tuser;
                if (in_beat && s_axis_tlast)
                begin
                    state_next = shbi_pkg::ST_FINAL;
                end
            end
            shbi_pkg::ST_FINAL:
            begin
                cmd.final_en = 1'b1;
                state_next   = shbi_pkg::ST_DIV;
            end
            shbi_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = shbi_pkg::ST_DONE;
                end
            end
            shbi_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = shbi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shbi_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

/* hdl/shbi_dp.sv */
// Datapath: running hash, final mix, bit-serial remainder unit and output register.
// Depends on shbi_pkg; commanded by shbi_ctrl.
`timescale 1ns / 1ps

module shbi_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [shbi_pkg::BYTE_W-1:0]         key_byte,
    input  logic                                cfg_wr_en,
    input  logic [shbi_pkg::HASH_W-1:0]         cfg_wr_data,
    input  shbi_pkg::shbi_cmd_t                 cmd,
    output shbi_pkg::shbi_status_t              status,
    output logic [shbi_pkg::OUT_W-1:0]          out_data
);

    localparam int HW = shbi_pkg::HASH_W;

    logic [HW-1:0]                 bucket_reg;
    logic [HW-1:0]                 hash_reg;
    logic [HW-1:0]                 hash_next;
    logic [HW-1:0]                 full_reg;
    logic [HW-1:0]                 dvd_reg;
    logic [HW-1:0]                 dsr_reg;
    logic [HW-1:0]                 rem_reg;
    logic [HW-1:0]                 rem_next;
    logic [shbi_pkg::CNT_W-1:0]    cnt_reg;
    logic [HW-1:0]                 out_hash_reg;
    logic [HW-1:0]                 out_idx_reg;
    logic [HW:0]                   trial;
    logic [HW:0]                   trial_diff;

    // Bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg <= shbi_pkg::BUCKET_RESET;
        end
        else if (cfg_wr_en)
        begin
            bucket_reg <= cfg_wr_data;
        end
    end

    // Running hash: mix on a present byte, clear once the key is finalized
    always_comb
    begin
        priority if (cmd.final_en)
        begin
            hash_next = '0;
        end
        else if (cmd.mix_en)
        begin
            hash_next = shbi_pkg::mix_byte(hash_reg, key_byte);
        end
        else
        begin
            hash_next = hash_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    // Restoring remainder step: one quotient bit per cycle
    assign trial      = {rem_reg, dvd_reg[HW-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign rem_next   = trial_diff[HW] ? trial[HW-1:0] : trial_diff[HW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.final_en)
        begin
            cnt_reg <= shbi_pkg::CNT_W'(shbi_pkg::DIV_STEPS - 1);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - shbi_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.final_en)
        begin
            full_reg <= shbi_pkg::final_mix(hash_reg);
            dvd_reg  <= shbi_pkg::final_mix(hash_reg);
            dsr_reg  <= bucket_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[HW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.div_done = (cnt_reg == '0);

    // Output register; a zero bucket count means 2^32 buckets
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hash_reg <= full_reg;
            out_idx_reg  <= (dsr_reg == '0) ? full_reg : rem_reg;
        end
    end

    assign out_data = {out_idx_reg, out_hash_reg};

endmodule

/* hdl/shbi_checker.sv */
// Port-level checker for string_hash_bucket_index, attached with bind.
// Depends on shbi_pkg for widths and result latency.
`timescale 1ns / 1ps

module shbi_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        s_axis_tlast,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [shbi_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int LAT = shbi_pkg::RESULT_LATENCY;

    logic last_beat;

    assign last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The end of a key makes the input busy in the next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_beat |=> !s_axis_tready)
        else $error("input still ready after last beat");

    // Input only goes busy because a key ended
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(last_beat))
        else $error("input went busy without a last beat");

    // A fresh result shows a fixed time after its key ended
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(last_beat, LAT))
        else $error("result appeared without a matching last beat");

endmodule

bind string_hash_bucket_index shbi_checker u_shbi_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
